// ===== rtl/swm_pkg.sv =====
// Shared types and fixed widths for the sliding-window median filter.
`default_nettype none
package swm_pkg;

  localparam int unsigned WinW = 6;
  localparam int unsigned SampleInW = 32;
  localparam int unsigned OutW = 33;

  typedef struct packed {
    logic upd;
    logic full;
  } swm_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/swm_cell.sv =====
// One slot of the sorted window: holds a sample and its age, and shifts with its neighbours.
`default_nettype none
module swm_cell import swm_pkg::*; #(
  parameter int unsigned IDX         = 0,
  parameter int unsigned MAX_WINDOW  = 32,
  parameter int unsigned SAMPLE_BITS = 32,
  localparam int unsigned AgeW       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
  localparam int unsigned CntW       = $clog2(MAX_WINDOW + 1)
) (
  input  wire logic                          clk_i,
  input  wire swm_ctrl_t                     ctrl_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire logic [CntW-1:0]               win_i,
  input  wire logic [CntW-1:0]               count_i,
  input  wire logic [CntW-1:0]               n_rem_i,
  input  wire logic                          rb_prev_i,
  input  wire logic signed [SAMPLE_BITS-1:0] nxt_val_i,
  input  wire logic [AgeW-1:0]               nxt_age_i,
  input  wire logic signed [SAMPLE_BITS-1:0] prev_rval_i,
  input  wire logic [AgeW-1:0]               prev_rage_i,
  input  wire logic                          prev_lt_i,
  output logic                               evict_o,
  output logic                               rb_o,
  output logic signed [SAMPLE_BITS-1:0]      rval_o,
  output logic [AgeW-1:0]                    rage_o,
  output logic                               lt_o,
  output logic signed [SAMPLE_BITS-1:0]      val_o,
  output logic [AgeW-1:0]                    age_o
);

  logic signed [SAMPLE_BITS-1:0] val_q, val_d;
  logic [AgeW-1:0]               age_q, age_d;

  always_comb begin
    evict_o = ctrl_i.full && (CntW'(IDX) < count_i) &&
              (CntW'(age_q) == (win_i - CntW'(1)));
    rb_o    = rb_prev_i | evict_o;
    rval_o  = rb_o ? nxt_val_i : val_q;
    rage_o  = rb_o ? nxt_age_i : age_q;
    lt_o    = (CntW'(IDX) < n_rem_i) && (rval_o < sample_i);
    if (lt_o) begin
      val_d = rval_o;
      age_d = rage_o + AgeW'(1);
    end else if (prev_lt_i) begin
      val_d = sample_i;
      age_d = '0;
    end else begin
      val_d = prev_rval_i;
      age_d = prev_rage_i + AgeW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.upd) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign val_o = val_q;
  assign age_o = age_q;

endmodule
`default_nettype wire

// ===== rtl/sliding_window_median.sv =====
// Top level of the sliding-window median filter: cell row, fill control and output register.
//
//   channel   signals                             payload
//   input     in_valid_i / in_ready_o             sample_i, start_req_i
//   output    out_valid_o / out_ready_i           median_twice_o
//   config    cfg_we_i                            cfg_wdata_i (window size)
//
// One beat is taken per cycle while in_ready_o is high; every cell updates its slot in the
// cycle of acceptance. A beat that fills the window sets pend_q; the result is loaded into
// the output register when free; input stalls only while pend_q is set and it is not free.
// Reset clears the fill count and sets the window size to three; sample slots need no reset.
`default_nettype none
module sliding_window_median import swm_pkg::*; #(
  parameter int unsigned MAX_WINDOW  = 32,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [WinW-1:0]        cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic signed [SampleInW-1:0] sample_i,
  input  wire logic                   start_req_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic signed [OutW-1:0]      median_twice_o
);

  localparam int unsigned AgeW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CntW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CmpW = (CntW > WinW) ? CntW : WinW;

  logic [WinW-1:0]  window_q;
  logic [CntW-1:0]  count_q, count_d;
  logic             pend_q, pend_d;
  logic             out_valid_q, out_valid_d;
  logic signed [OutW-1:0] median_q, median_d;

  logic [CmpW-1:0]  win_ext, win_sat;
  logic [CntW-1:0]  win_eff, count_eff, n_rem, lo_idx, hi_idx;
  logic             accept, full, out_free;
  logic signed [SAMPLE_BITS-1:0] samp;
  logic signed [SAMPLE_BITS-1:0] lo_val, hi_val;
  logic signed [SAMPLE_BITS:0]   pair_sum;
  swm_ctrl_t        ctrl;

  logic signed [SAMPLE_BITS-1:0] val_w  [MAX_WINDOW];
  logic [AgeW-1:0]               age_w  [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] rval_w [MAX_WINDOW];
  logic [AgeW-1:0]               rage_w [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]         lt_w, rb_w, evict_w;

  always_comb begin
    win_ext = CmpW'(window_q);
    if (win_ext == '0) begin
      win_sat = CmpW'(1);
    end else if (win_ext > CmpW'(MAX_WINDOW)) begin
      win_sat = CmpW'(MAX_WINDOW);
    end else begin
      win_sat = win_ext;
    end
    win_eff   = win_sat[CntW-1:0];
    lo_idx    = (win_eff - CntW'(1)) >> 1;
    hi_idx    = win_eff >> 1;
    out_free  = !out_valid_q || out_ready_i;
    in_ready_o = !pend_q || out_free;
    accept    = in_valid_i && in_ready_o;
    samp      = sample_i[SAMPLE_BITS-1:0];
    count_eff = start_req_i ? '0 : count_q;
    full      = (count_eff == win_eff);
    n_rem     = full ? (win_eff - CntW'(1)) : count_eff;
    ctrl.upd  = accept;
    ctrl.full = full;
  end

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    logic                          rb_prev, prev_lt;
    logic signed [SAMPLE_BITS-1:0] nxt_val, prev_rval;
    logic [AgeW-1:0]               nxt_age, prev_rage;

    if (g == 0) begin : g_first
      assign rb_prev   = 1'b0;
      assign prev_lt   = 1'b1;
      assign prev_rval = '0;
      assign prev_rage = '0;
    end else begin : g_mid
      assign rb_prev   = rb_w[g-1];
      assign prev_lt   = lt_w[g-1];
      assign prev_rval = rval_w[g-1];
      assign prev_rage = rage_w[g-1];
    end

    if (g == MAX_WINDOW - 1) begin : g_last
      assign nxt_val = '0;
      assign nxt_age = '0;
    end else begin : g_inner
      assign nxt_val = val_w[g+1];
      assign nxt_age = age_w[g+1];
    end

    swm_cell #(
      .IDX         (g),
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .sample_i    (samp),
      .win_i       (win_eff),
      .count_i     (count_eff),
      .n_rem_i     (n_rem),
      .rb_prev_i   (rb_prev),
      .nxt_val_i   (nxt_val),
      .nxt_age_i   (nxt_age),
      .prev_rval_i (prev_rval),
      .prev_rage_i (prev_rage),
      .prev_lt_i   (prev_lt),
      .evict_o     (evict_w[g]),
      .rb_o        (rb_w[g]),
      .rval_o      (rval_w[g]),
      .rage_o      (rage_w[g]),
      .lt_o        (lt_w[g]),
      .val_o       (val_w[g]),
      .age_o       (age_w[g])
    );
  end

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      lo_val = lo_val | (val_w[i] & {SAMPLE_BITS{CntW'(i) == lo_idx}});
      hi_val = hi_val | (val_w[i] & {SAMPLE_BITS{CntW'(i) == hi_idx}});
    end
    pair_sum = (SAMPLE_BITS+1)'(lo_val) + (SAMPLE_BITS+1)'(hi_val);
  end

  always_comb begin
    count_d     = count_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    median_d    = median_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pend_q && out_free) begin
      out_valid_d = 1'b1;
      median_d    = OutW'(pair_sum);
      pend_d      = 1'b0;
    end
    if (accept) begin
      count_d = full ? win_eff : (count_eff + CntW'(1));
      pend_d  = (count_d == win_eff);
    end
    if (cfg_we_i) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= WinW'(3);
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    median_q <= median_d;
  end

  assign out_valid_o    = out_valid_q;
  assign median_twice_o = median_q;

  a_count_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |-> (count_q <= win_eff))
    else $error("fill count exceeds the window");

  a_single_evict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> $onehot(evict_w))
    else $error("a full window must evict exactly one sample");

  a_no_evict_filling : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |-> (evict_w == '0))
    else $error("eviction while the window is still filling");

  a_full_beat_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && full && !cfg_we_i) |=> pend_q)
    else $error("a beat on a full window gave no result");

  a_pending_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && out_free) |=> out_valid_q)
    else $error("pending result was not loaded into the output register");

endmodule
`default_nettype wire
